// File: hw/rtl/spq_pkg.sv
// Shared types and codes for the stable sorted priority queue.
package spq_pkg;

  // Width of the capacity register
  localparam int unsigned CAP_BITS = 9;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 9'd256;

  // Operation codes on in_func
  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// File: hw/rtl/stable_sorted_priority_queue.sv
// Stable sorted-array min-priority queue: top level with control and storage.
//
// Entries are kept sorted by key in a circular buffer in one RAM (key and
// handle side by side); the smallest key sits at the head pointer. Equal keys
// leave in arrival order. Pulse start while busy is low to issue an operation;
// each operation yields exactly one result, shown for one cycle with out_valid,
// and the receiver cannot stall it. A remove reads the head from RAM, then gives
// the result. A rejected insert or remove answers straight from idle. An insert
// opens a hole at the tail; each stored entry with a key larger than the new one
// then moves up into the hole, one entry per cycle through the single read and
// single write port of the RAM, and the new entry is written into the hole. The
// RAM needs no clearing after reset; only positions already written are ever read.
module stable_sorted_priority_queue #(
  parameter int unsigned DEPTH       = 256,
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // command channel
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_func,
  input  logic [KEY_BITS-1:0]                in_item_key,
  input  logic [HANDLE_BITS-1:0]             in_item_handle,
  // configuration
  input  logic                               cfg_we,
  input  logic [spq_pkg::CAP_BITS-1:0]       cfg_wdata,
  // result channel
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [KEY_BITS-1:0]                out_key,
  output logic [HANDLE_BITS-1:0]             out_handle,
  output logic [$clog2(DEPTH+1)-1:0]         out_entry_count,
  output logic                               out_is_empty,
  output logic                               out_is_full
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned SW   = CW + 1;
  localparam int unsigned CMPW = (CW > spq_pkg::CAP_BITS) ? CW : spq_pkg::CAP_BITS;
  localparam int unsigned DW   = KEY_BITS + HANDLE_BITS;

  typedef enum logic [1:0] {
    IDLE,
    SHIFT,
    PLACE,
    POP
  } state_t;

  state_t                      state_r, state_nxt;
  logic [AW-1:0]               head_r, head_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [AW-1:0]               hole_r, hole_nxt;
  logic [CW-1:0]               pos_r, pos_nxt;
  logic [KEY_BITS-1:0]         key_r, key_nxt;
  logic [HANDLE_BITS-1:0]      handle_r, handle_nxt;
  logic [spq_pkg::CAP_BITS-1:0] cap_r;

  logic                        out_valid_nxt;
  logic [1:0]                  out_status_nxt;
  logic [KEY_BITS-1:0]         out_key_nxt;
  logic [HANDLE_BITS-1:0]      out_handle_nxt;
  logic [CW-1:0]               out_count_nxt;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [DW-1:0]               ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [DW-1:0]               ram_rdata;
  logic [KEY_BITS-1:0]         rd_key;
  logic [HANDLE_BITS-1:0]      rd_handle;

  logic                        accept;
  logic [CMPW-1:0]             eff_cap;
  logic                        cur_full;
  logic [SW-1:0]               tail_sum;
  logic [AW-1:0]               tail;
  logic [AW-1:0]               head_inc;
  logic [AW-1:0]               hole_dec;
  logic [AW-1:0]               hole_nxt_dec;

  assign busy   = (state_r != IDLE);
  assign accept = start && !busy;

  assign rd_key    = ram_rdata[DW-1:HANDLE_BITS];
  assign rd_handle = ram_rdata[HANDLE_BITS-1:0];

  // Clamp the capacity to the depth
  assign eff_cap  = (CMPW'(cap_r) > CMPW'(DEPTH)) ? CMPW'(DEPTH) : CMPW'(cap_r);
  assign cur_full = (CMPW'(count_r) >= eff_cap);

  // Physical address one past the last entry
  always_comb begin
    tail_sum = SW'(head_r) + SW'(count_r);
    if (tail_sum >= SW'(DEPTH)) begin
      tail_sum = tail_sum - SW'(DEPTH);
    end
    tail = tail_sum[AW-1:0];
  end

  // Wrapping pointer steps
  assign head_inc     = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign hole_dec     = (hole_r == '0) ? AW'(DEPTH - 1) : hole_r - AW'(1);
  assign hole_nxt_dec = (hole_nxt == '0) ? AW'(DEPTH - 1) : hole_nxt - AW'(1);

  // Sequencer next-state and RAM control
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    hole_nxt       = hole_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    handle_nxt     = handle_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = spq_pkg::ST_DONE;
    out_key_nxt    = '0;
    out_handle_nxt = '0;
    out_count_nxt  = count_r;
    ram_we         = 1'b0;
    ram_waddr      = hole_r;
    ram_wdata      = {key_r, handle_r};
    ram_raddr      = hole_nxt_dec;

    case (state_r)
      IDLE: begin
        if (accept) begin
          if (in_func == spq_pkg::FUNC_INSERT) begin
            if (cur_full) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = spq_pkg::ST_FULL;
            end else begin
              // Open a hole at the tail and start probing below it
              key_nxt    = in_item_key;
              handle_nxt = in_item_handle;
              hole_nxt   = tail;
              pos_nxt    = count_r;
              state_nxt  = (count_r == '0) ? PLACE : SHIFT;
            end
          end else begin
            if (count_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = spq_pkg::ST_EMPTY;
            end else begin
              // Read the head entry
              ram_raddr = head_r;
              state_nxt = POP;
            end
          end
        end
      end

      SHIFT: begin
        if (rd_key > key_r) begin
          // Move the larger entry up into the hole and step down
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          hole_nxt  = hole_dec;
          pos_nxt   = pos_r - CW'(1);
          if (pos_r == CW'(1)) begin
            state_nxt = PLACE;
          end
        end else begin
          // Found the slot: drop the new entry in
          ram_we         = 1'b1;
          count_nxt      = count_r + CW'(1);
          out_valid_nxt  = 1'b1;
          out_count_nxt  = count_r + CW'(1);
          state_nxt      = IDLE;
        end
      end

      PLACE: begin
        ram_we        = 1'b1;
        count_nxt     = count_r + CW'(1);
        out_valid_nxt = 1'b1;
        out_count_nxt = count_r + CW'(1);
        state_nxt     = IDLE;
      end

      POP: begin
        head_nxt       = head_inc;
        count_nxt      = count_r - CW'(1);
        out_valid_nxt  = 1'b1;
        out_key_nxt    = rd_key;
        out_handle_nxt = rd_handle;
        out_count_nxt  = count_r - CW'(1);
        state_nxt      = IDLE;
      end

      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  // Hold state, pointers and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= IDLE;
      head_r          <= '0;
      count_r         <= '0;
      cap_r           <= spq_pkg::CAP_RESET;
      out_valid       <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      head_r          <= head_nxt;
      count_r         <= count_nxt;
      out_valid       <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
    hole_r          <= hole_nxt;
    pos_r           <= pos_nxt;
    key_r           <= key_nxt;
    handle_r        <= handle_nxt;
    out_status      <= out_status_nxt;
    out_key         <= out_key_nxt;
    out_handle      <= out_handle_nxt;
    out_entry_count <= out_count_nxt;
    out_is_empty    <= (out_count_nxt == '0);
    out_is_full     <= (CMPW'(out_count_nxt) >= eff_cap);
  end

  // Entry storage: key above handle
  spq_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A result transfer always finishes the operation
  a_result_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // An accepted remove on a nonempty queue returns its entry once the POP state has passed and the result is registered
  a_pop_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == spq_pkg::FUNC_REMOVE && count_r != '0)
      |=> ##1 (out_valid && out_status == spq_pkg::ST_DONE))
    else $error("remove result missing or wrong status");

  // The count moves only together with a result
  a_count_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r)) |-> out_valid)
    else $error("count changed without a result");

endmodule

// File: hw/rtl/spq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module spq_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: dv/stable_sorted_priority_queue_tb.sv
// Self-checking testbench for the stable sorted priority queue: directed and random commands.
`timescale 1ns / 100ps

module stable_sorted_priority_queue_tb;

  localparam int unsigned DEPTH       = 256;
  localparam int unsigned KEY_BITS    = 32;
  localparam int unsigned HANDLE_BITS = 16;
  localparam int unsigned COUNT_BITS  = $clog2(DEPTH + 1);
  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct {
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
  } queue_entry_t;

  typedef struct {
    spq_pkg::status_t       status;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
    logic [COUNT_BITS-1:0]  count;
    logic                   empty;
    logic                   full;
  } queue_result_t;

  // Shadow of the queue contents and the results it owes
  class pq_scoreboard;
    queue_entry_t  held_entries[$];
    queue_result_t pending_results[$];
    int unsigned   capacity;
    int            mismatches;
    int            n_commands;
    int            n_results;
    int            n_full_rejects;
    int            n_empty_rejects;
    int            peak_fill;

    function new();
      capacity = DEPTH;
    endfunction

    task automatic report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Apply one accepted command to the shadow queue and queue up its result
    function automatic void note_command(input spq_pkg::func_t func,
                                         input logic [KEY_BITS-1:0] key,
                                         input logic [HANDLE_BITS-1:0] handle);
      queue_result_t res;
      queue_entry_t  head;
      int unsigned   limit;
      int            pos;
      limit = (capacity > DEPTH) ? DEPTH : capacity;
      res.status = spq_pkg::ST_DONE;
      res.key = '0;
      res.handle = '0;
      if (func == spq_pkg::FUNC_INSERT) begin
        if (held_entries.size() >= limit) begin
          res.status = spq_pkg::ST_FULL;
          n_full_rejects++;
        end else begin
          // place after every entry with a key less than or equal to the new one
          pos = held_entries.size();
          while (pos > 0 && held_entries[pos-1].key > key) pos--;
          head.key = key;
          head.handle = handle;
          held_entries.insert(pos, head);
        end
      end else begin
        if (held_entries.size() == 0) begin
          res.status = spq_pkg::ST_EMPTY;
          n_empty_rejects++;
        end else begin
          head = held_entries.pop_front();
          res.key = head.key;
          res.handle = head.handle;
        end
      end
      res.count = COUNT_BITS'(held_entries.size());
      res.empty = (held_entries.size() == 0);
      res.full = (held_entries.size() >= limit);
      if (held_entries.size() > peak_fill) peak_fill = held_entries.size();
      pending_results.push_back(res);
      n_commands++;
    endfunction

    // Compare one result transfer with the oldest outstanding prediction
    task automatic check_result(input queue_result_t got);
      queue_result_t want;
      n_results++;
      if (pending_results.size() == 0) begin
        report("result with no command outstanding");
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.key !== want.key)
          report($sformatf("key got %h want %h", got.key, want.key));
        if (got.handle !== want.handle)
          report($sformatf("handle got %h want %h", got.handle, want.handle));
        if (got.count !== want.count)
          report($sformatf("entry_count got %0d want %0d", got.count, want.count));
        if (got.empty !== want.empty)
          report($sformatf("is_empty got %b want %b", got.empty, want.empty));
        if (got.full !== want.full)
          report($sformatf("is_full got %b want %b", got.full, want.full));
      end
    endtask
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic                           in_func;
  logic [KEY_BITS-1:0]            in_item_key;
  logic [HANDLE_BITS-1:0]         in_item_handle;
  logic                           cfg_we;
  logic [spq_pkg::CAP_BITS-1:0]   cfg_wdata;
  logic                           out_valid;
  logic [1:0]                     out_status;
  logic [KEY_BITS-1:0]            out_key;
  logic [HANDLE_BITS-1:0]         out_handle;
  logic [COUNT_BITS-1:0]          out_entry_count;
  logic                           out_is_empty;
  logic                           out_is_full;

  pq_scoreboard sb = new();
  int           stall_cycles;

  stable_sorted_priority_queue #(
    .DEPTH(DEPTH),
    .KEY_BITS(KEY_BITS),
    .HANDLE_BITS(HANDLE_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_func(in_func),
    .in_item_key(in_item_key),
    .in_item_handle(in_item_handle),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_key(out_key),
    .out_handle(out_handle),
    .out_entry_count(out_entry_count),
    .out_is_empty(out_is_empty),
    .out_is_full(out_is_full)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check results, record command transfers and watch for a hang
  always @(posedge clk) begin
    queue_result_t got;
    if (!rst_n) begin
      stall_cycles = 0;
    end else begin
      if (out_valid) begin
        got.status = spq_pkg::status_t'(out_status);
        got.key = out_key;
        got.handle = out_handle;
        got.count = out_entry_count;
        got.empty = out_is_empty;
        got.full = out_is_full;
        sb.check_result(got);
      end
      if (start && !busy)
        sb.note_command(spq_pkg::func_t'(in_func), in_item_key, in_item_handle);
      if (out_valid || (start && !busy)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
          $display("FAIL stable_sorted_priority_queue");
          $finish;
        end
      end
    end
  end

  // Hold one command on the bus until the block takes it
  task automatic issue(input spq_pkg::func_t func, input logic [KEY_BITS-1:0] key,
                       input logic [HANDLE_BITS-1:0] handle);
    in_func = func;
    in_item_key = key;
    in_item_handle = handle;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drop start for a random number of cycles: often not at all, else mostly short, sometimes long
  task automatic idle_gap(input bit no_idle);
    int pick;
    int cycles;
    pick = $urandom_range(0, 99);
    cycles = 0;
    if (!no_idle) begin
      if (pick >= 90) cycles = $urandom_range(5, 30);
      else if (pick >= 50) cycles = $urandom_range(1, 3);
    end
    if (cycles > 0) begin
      start = 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Hold off until every outstanding result has come back and the block is idle
  task automatic drain();
    start = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input int unsigned value);
    drain();
    cfg_wdata = value[spq_pkg::CAP_BITS-1:0];
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.capacity = value & ((1 << spq_pkg::CAP_BITS) - 1);
  endtask

  // Keys: a narrow range for ties, the extremes, or anything
  function automatic logic [KEY_BITS-1:0] pick_key();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return $urandom_range(0, 7);
    if (pick < 6) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        2: return 1;
        default: return '1 - 1;
      endcase
    end
    return $urandom;
  endfunction

  // One random phase: mostly inserts in the first half, mostly removes after
  task automatic run_phase(input int unsigned cap, input int n_items, input int insert_pct);
    bit no_idle;
    int pct;
    write_capacity(cap);
    no_idle = 1'b0;
    for (int i = 0; i < n_items; i++) begin
      if (i % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 49) == 0) drain();
      pct = (i < n_items / 2) ? insert_pct : 100 - insert_pct;
      if ($urandom_range(1, 100) <= pct)
        issue(spq_pkg::FUNC_INSERT, pick_key(), HANDLE_BITS'($urandom));
      else
        issue(spq_pkg::FUNC_REMOVE, $urandom, HANDLE_BITS'($urandom));
      idle_gap(no_idle);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_func = spq_pkg::FUNC_INSERT;
    in_item_key = '0;
    in_item_handle = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset capacity: empty remove, extremes and equal keys leaving in order
    issue(spq_pkg::FUNC_REMOVE, '1, '1);
    issue(spq_pkg::FUNC_INSERT, '1, '1);
    issue(spq_pkg::FUNC_INSERT, '0, '0);
    issue(spq_pkg::FUNC_INSERT, 5, 1);
    issue(spq_pkg::FUNC_INSERT, 5, 2);
    issue(spq_pkg::FUNC_INSERT, 5, 3);
    issue(spq_pkg::FUNC_INSERT, '0, 4);
    issue(spq_pkg::FUNC_INSERT, '1, 5);
    repeat (8) issue(spq_pkg::FUNC_REMOVE, '0, '0);

    // Capacity of zero: full while empty
    write_capacity(0);
    issue(spq_pkg::FUNC_INSERT, 9, 9);
    issue(spq_pkg::FUNC_REMOVE, 0, 0);

    // Capacity above depth, then lowered below the count
    write_capacity((1 << spq_pkg::CAP_BITS) - 1);
    issue(spq_pkg::FUNC_INSERT, 7, 16'h00a1);
    issue(spq_pkg::FUNC_INSERT, 3, 16'h00a2);
    issue(spq_pkg::FUNC_INSERT, 7, 16'h00a3);
    write_capacity(2);
    issue(spq_pkg::FUNC_INSERT, 1, 16'h00a4);
    issue(spq_pkg::FUNC_REMOVE, 0, 0);
    issue(spq_pkg::FUNC_REMOVE, 0, 0);
    issue(spq_pkg::FUNC_INSERT, 2, 16'h00a5);

    // Random phases over a spread of capacities, one filling to depth
    run_phase((1 << spq_pkg::CAP_BITS) - 1, 540, 97);
    run_phase(1, 50, 60);
    run_phase(DEPTH, 50, 70);
    run_phase(9, 50, 70);
    run_phase($urandom_range(2, 40), 50, 65);

    drain();
    repeat (20) @(negedge clk);
    if (sb.pending_results.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));

    $display("Covered %0d commands and %0d results, peak fill %0d of %0d.",
             sb.n_commands, sb.n_results, sb.peak_fill, DEPTH);
    $display("Rejected %0d inserts on a full queue and %0d removes on an empty one.",
             sb.n_full_rejects, sb.n_empty_rejects);
    if (sb.mismatches == 0) begin
      $display("PASS stable_sorted_priority_queue");
    end else begin
      $display("FAIL stable_sorted_priority_queue");
    end
    $finish;
  end

endmodule
